/* rtl/gsa_pkg.sv */
// Shared codes and defaults for the generational slot allocator.
// Request kinds, result status codes, default table geometry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gsa_pkg;

	localparam int DefSlotCount   = 64;
	localparam int DefVersionBits = 16;

	localparam int KindW   = 2;
	localparam int IndexW  = 6;
	localparam int VerW    = 16;
	localparam int StatusW = 2;

	typedef enum logic [KindW-1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_CHECK = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [StatusW-1:0] {
		ST_OK       = 2'd0,
		ST_NOT_USED = 2'd1,
		ST_STALE    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

endpackage
`default_nettype wire

/* rtl/gsa_ver_mem.sv */
// Slot version memory: one write port, one read port, registered read data.
// Read data holds until the next read enable. Uses gsa_pkg defaults.
`timescale 1ns / 1ps
`default_nettype none
module gsa_ver_mem
	import gsa_pkg::*;
#(
	parameter int DEPTH = DefSlotCount,
	parameter int AW    = $clog2(DefSlotCount),
	parameter int DW    = DefVersionBits
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/generational_slot_allocator.sv */
// Generational slot allocator: handle table of versioned slots.
// Channels: request (kind, handle_index, handle_version) on req_valid/req_stall,
// result (status, slot_index, slot_version) on rsp_valid/rsp_stall.
// Each request gives exactly one result, in request order.
// Requests are taken one at a time because of the version memory
// read-modify-write: on acceptance the slot version read is registered
// (allocate picks the lowest inactive slot in use with a priority encoder
// over the active flags, else the next slot to grow onto), then the busy
// stage checks, writes back and loads the result register.
// req_stall is high while a request is in flight; at most one is in flight.
// When rsp_stall holds a result, a finished request waits in the busy
// stage until the result register frees, and req_stall stays high.
// Reset clears active flags, the in-use count and the valid bits at once;
// no clearing pass runs. A slot gets its zero version written when the table
// grows onto it, so version memory entries need no reset.
// Status: 0 ok, 1 index not in use, 2 stale or inactive, 3 table full.
`timescale 1ns / 1ps
`default_nettype none
module generational_slot_allocator
	import gsa_pkg::*;
#(
	parameter int SLOT_COUNT   = DefSlotCount,
	parameter int VERSION_BITS = DefVersionBits
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [KindW-1:0]   kind,
	input  wire logic [IndexW-1:0]  handle_index,
	input  wire logic [VerW-1:0]    handle_version,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic [StatusW-1:0]      status,
	output logic [IndexW-1:0]       slot_index,
	output logic [VerW-1:0]         slot_version
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int USE_W = $clog2(SLOT_COUNT + 1);
	localparam int CMP_W = (USE_W > IndexW) ? USE_W : IndexW;
	localparam int VCM_W = (VERSION_BITS > VerW) ? VERSION_BITS : VerW;

	logic [SLOT_COUNT-1:0]   active_q;
	logic [USE_W-1:0]        in_use_q;
	logic                    busy_s1;
	logic                    rsp_valid_q;
	logic [StatusW-1:0]      status_q;
	logic [IndexW-1:0]       slot_index_q;
	logic [VerW-1:0]         slot_version_q;

	kind_t                   kind_s1;
	logic [IndexW-1:0]       hidx_s1;
	logic [VerW-1:0]         hver_s1;
	logic [IDX_W-1:0]        addr_s1;
	logic                    in_range_s1;
	logic                    grow_s1;
	logic                    full_s1;

	logic                    req_acc;
	logic                    done;
	logic [IDX_W-1:0]        pick;
	logic                    found;
	logic                    is_alloc;
	logic [IDX_W-1:0]        rd_addr;
	logic [VERSION_BITS-1:0] ver_rd;
	logic                    wr_en;
	logic [VERSION_BITS-1:0] wr_data;
	status_t                 chk_st;
	status_t                 res_st;
	logic [IndexW-1:0]       res_idx;
	logic [VerW-1:0]         res_ver;

	assign req_stall = busy_s1;
	assign req_acc   = req_valid && !busy_s1;
	assign done      = busy_s1 && (!rsp_valid_q || !rsp_stall);
	assign is_alloc  = (kind_t'(kind) == KIND_ALLOC);

	// lowest inactive slot among those in use
	always_comb begin
		pick  = '0;
		found = 1'b0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (i < int'(in_use_q) && !active_q[i]) begin
				pick  = IDX_W'(i);
				found = 1'b1;
			end
		end
	end

	assign rd_addr = is_alloc ? (found ? pick : IDX_W'(in_use_q)) : IDX_W'(handle_index);

	gsa_ver_mem #(
		.DEPTH (SLOT_COUNT),
		.AW    (IDX_W),
		.DW    (VERSION_BITS)
	) u_ver_mem (
		.clk     (clk),
		.rd_en   (req_acc),
		.rd_addr (rd_addr),
		.rd_data (ver_rd),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk) begin
		if (req_acc) begin
			kind_s1     <= kind_t'(kind);
			hidx_s1     <= handle_index;
			hver_s1     <= handle_version;
			addr_s1     <= rd_addr;
			in_range_s1 <= CMP_W'(handle_index) < CMP_W'(in_use_q);
			grow_s1     <= is_alloc && !found && (in_use_q != USE_W'(SLOT_COUNT));
			full_s1     <= is_alloc && !found && (in_use_q == USE_W'(SLOT_COUNT));
		end
	end

	always_comb begin
		if (!in_range_s1) begin
			chk_st = ST_NOT_USED;
		end else if (VCM_W'(ver_rd) != VCM_W'(hver_s1) || !active_q[addr_s1]) begin
			chk_st = ST_STALE;
		end else begin
			chk_st = ST_OK;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_data = ver_rd + VERSION_BITS'(1);
		res_st  = chk_st;
		res_idx = hidx_s1;
		res_ver = '0;
		case (kind_s1)
			KIND_ALLOC: begin
				if (full_s1) begin
					res_st  = ST_FULL;
					res_idx = '0;
				end else begin
					res_st  = ST_OK;
					res_idx = IndexW'(addr_s1);
					res_ver = grow_s1 ? '0 : VerW'(ver_rd);
					wr_en   = done && grow_s1;
					wr_data = '0;
				end
			end
			KIND_FREE: begin
				wr_en = done && (chk_st == ST_OK);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
			active_q    <= '0;
			in_use_q    <= '0;
		end else begin
			if (req_acc) begin
				busy_s1 <= 1'b1;
			end else if (done) begin
				busy_s1 <= 1'b0;
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (done && kind_s1 == KIND_ALLOC && !full_s1) begin
				active_q[addr_s1] <= 1'b1;
				if (grow_s1) begin
					in_use_q <= in_use_q + USE_W'(1);
				end
			end
			if (done && kind_s1 == KIND_FREE && chk_st == ST_OK) begin
				active_q[addr_s1] <= 1'b0;
			end
		end
	end

	// hold result while stalled
	always_ff @(posedge clk) begin
		if (done) begin
			status_q       <= res_st;
			slot_index_q   <= res_idx;
			slot_version_q <= res_ver;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign slot_index   = slot_index_q;
	assign slot_version = slot_version_q;

`ifndef SYNTHESIS
	a_use_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_use_q <= USE_W'(SLOT_COUNT))
		else $error("in-use count beyond table size");

	a_full_only_when_grown: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && status_q == ST_FULL) |-> (in_use_q == USE_W'(SLOT_COUNT)))
		else $error("table full reported before table grew to size");

	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(busy_s1))
		else $error("result without request in flight");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy_s1 || $past(req_acc))
		else $error("request stage stayed busy after completion");
`endif

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for generational_slot_allocator.
// Drives directed, slot-reuse, random and table-fill request streams and checks every
// result against a fixed expected row or an in-bench slot table model. Depends on rtl/gsa_pkg.sv and the RTL.
`timescale 1ns / 1ps
module tb_top;
	import gsa_pkg::*;

	localparam int SLOTS          = DefSlotCount;
	localparam int CYCLE_REQUESTS = 200;
	localparam int SEGMENTS       = 10;
	localparam int SEGMENT_LEN    = 120;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 10;
	localparam int DIRECTED_ROWS  = 23;

	typedef struct packed {
		status_t           st;
		logic [IndexW-1:0] idx;
		logic [VerW-1:0]   ver;
	} result_t;

	typedef struct packed {
		kind_t             op;
		logic [IndexW-1:0] idx;
		logic [VerW-1:0]   ver;
		logic              typed;
		result_t           res;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [KindW-1:0]   kind = '0;
	logic [IndexW-1:0]  handle_index = '0;
	logic [VerW-1:0]    handle_version = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [StatusW-1:0] status;
	logic [IndexW-1:0]  slot_index;
	logic [VerW-1:0]    slot_version;

	// slot table model
	logic            slot_live [SLOTS];
	logic [VerW-1:0] slot_gen [SLOTS];
	int              slots_grown = 0;
	int              live_count = 0;

	result_t pending_results [$];
	int      mismatches = 0;
	int      idle_cycles = 0;
	int      burst_left = 0;
	int      gap = 0;
	bit      hold_long = 1'b0;

	stim_row_t directed [DIRECTED_ROWS] = '{
		'{KIND_CHECK, 6'd0,  16'h0000, 1'b1, '{ST_NOT_USED, 6'd0,  16'h0000}},
		'{KIND_FREE,  6'd63, 16'hFFFF, 1'b1, '{ST_NOT_USED, 6'd63, 16'h0000}},
		'{KIND_NONE,  6'd63, 16'h0000, 1'b1, '{ST_NOT_USED, 6'd63, 16'h0000}},
		'{KIND_ALLOC, 6'd63, 16'hFFFF, 1'b1, '{ST_OK,       6'd0,  16'h0000}},
		'{KIND_ALLOC, 6'd0,  16'h0000, 1'b1, '{ST_OK,       6'd1,  16'h0000}},
		'{KIND_CHECK, 6'd0,  16'h0000, 1'b1, '{ST_OK,       6'd0,  16'h0000}},
		'{KIND_CHECK, 6'd1,  16'hFFFF, 1'b1, '{ST_STALE,    6'd1,  16'h0000}},
		'{KIND_CHECK, 6'd2,  16'h0000, 1'b1, '{ST_NOT_USED, 6'd2,  16'h0000}},
		'{KIND_FREE,  6'd0,  16'h0001, 1'b1, '{ST_STALE,    6'd0,  16'h0000}},
		'{KIND_FREE,  6'd0,  16'h0000, 1'b1, '{ST_OK,       6'd0,  16'h0000}},
		'{KIND_CHECK, 6'd0,  16'h0001, 1'b1, '{ST_STALE,    6'd0,  16'h0000}},
		'{KIND_FREE,  6'd0,  16'h0001, 1'b1, '{ST_STALE,    6'd0,  16'h0000}},
		'{KIND_NONE,  6'd1,  16'h0000, 1'b1, '{ST_OK,       6'd1,  16'h0000}},
		'{KIND_ALLOC, 6'd0,  16'h0000, 1'b1, '{ST_OK,       6'd0,  16'h0001}},
		'{KIND_CHECK, 6'd0,  16'h0001, 1'b1, '{ST_OK,       6'd0,  16'h0000}},
		'{KIND_FREE,  6'd1,  16'h0000, 1'b1, '{ST_OK,       6'd1,  16'h0000}},
		'{KIND_FREE,  6'd0,  16'h0001, 1'b1, '{ST_OK,       6'd0,  16'h0000}},
		'{KIND_ALLOC, 6'd0,  16'h0000, 1'b1, '{ST_OK,       6'd0,  16'h0002}},
		'{KIND_ALLOC, 6'd0,  16'h0000, 1'b1, '{ST_OK,       6'd1,  16'h0001}},
		'{KIND_ALLOC, 6'd0,  16'h0000, 1'b1, '{ST_OK,       6'd2,  16'h0000}},
		'{KIND_NONE,  6'd0,  16'h0002, 1'b0, '{ST_OK,       6'd0,  16'h0000}},
		'{KIND_FREE,  6'd2,  16'h0000, 1'b0, '{ST_OK,       6'd0,  16'h0000}},
		'{KIND_CHECK, 6'd2,  16'h0001, 1'b0, '{ST_OK,       6'd0,  16'h0000}}
	};

	generational_slot_allocator uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.kind           (kind),
		.handle_index   (handle_index),
		.handle_version (handle_version),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.status         (status),
		.slot_index     (slot_index),
		.slot_version   (slot_version)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t slot_table_step(kind_t op, logic [IndexW-1:0] idx,
			logic [VerW-1:0] ver);
		result_t r;
		int pick;
		r = '{ST_OK, idx, '0};
		pick = -1;
		if (op == KIND_ALLOC) begin
			for (int i = 0; i < slots_grown; i++)
				if (!slot_live[i] && pick < 0)
					pick = i;
			if (pick < 0 && slots_grown == SLOTS) begin
				r = '{ST_FULL, '0, '0};
				return r;
			end
			if (pick < 0) begin
				pick = slots_grown;
				slots_grown++;
				slot_gen[pick] = '0;
			end
			slot_live[pick] = 1'b1;
			live_count++;
			r.idx = pick[IndexW-1:0];
			r.ver = slot_gen[pick];
			return r;
		end
		if (idx >= slots_grown)
			r.st = ST_NOT_USED;
		else if (slot_gen[idx] != ver || !slot_live[idx])
			r.st = ST_STALE;
		else if (op == KIND_FREE) begin
			slot_live[idx] = 1'b0;
			slot_gen[idx] = slot_gen[idx] + 1'b1;
			live_count--;
		end
		return r;
	endfunction

	task automatic issue(input kind_t op, input logic [IndexW-1:0] idx,
			input logic [VerW-1:0] ver, input logic typed, input result_t typed_res);
		result_t want;
		req_valid <= 1'b1;
		kind <= op;
		handle_index <= idx;
		handle_version <= ver;
		do @(posedge clk); while (req_stall);
		want = slot_table_step(op, idx, ver);
		pending_results.push_back(typed ? typed_res : want);
		if (burst_left > 0)
			burst_left--;
		else begin
			gap = $urandom_range(0, 6);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// receiver: stall patterns, plus one long hold on request
	initial begin : receiver
		int mode;
		int mode_left;
		int tick;
		mode = 0;
		mode_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				hold_long = 1'b0;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_stall <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(3);
					mode_left = $urandom_range(10, 200);
				end
				mode_left--;
				tick++;
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(3) == 0);
					2: rsp_stall <= (tick % 5 < 2);
					default: rsp_stall <= 1'($urandom_range(1));
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with none expected: status %0d slot_index %0d slot_version %0h",
					status, slot_index, slot_version);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					mismatches++;
				end
				if (slot_index !== want.idx) begin
					$error("slot_index: expected %0d, got %0d", want.idx, slot_index);
					mismatches++;
				end
				if (slot_version !== want.ver) begin
					$error("slot_version: expected %0h, got %0h", want.ver, slot_version);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : stimulus
		kind_t           op;
		logic [IndexW-1:0] idx;
		logic [VerW-1:0]   ver;
		int              alloc_pct;
		int              roll;
		foreach (slot_live[i]) begin
			slot_live[i] = 1'b0;
			slot_gen[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			issue(directed[i].op, directed[i].idx, directed[i].ver, directed[i].typed,
				directed[i].res);
		drain_results();

		// cycle slot 0 through a run of free and reallocate
		repeat (CYCLE_REQUESTS) begin
			if (slot_live[0])
				issue(KIND_FREE, 6'd0, slot_gen[0], 1'b0, '0);
			else
				issue(KIND_ALLOC, IndexW'($urandom), VerW'($urandom), 1'b0, '0);
		end
		drain_results();

		hold_long = 1'b1;
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			alloc_pct = $urandom_range(10, 80);
			repeat (SEGMENT_LEN) begin
				roll = $urandom_range(99);
				idx = IndexW'($urandom);
				ver = VerW'($urandom);
				if (roll < alloc_pct)
					op = KIND_ALLOC;
				else if ($urandom_range(4) != 0 && slots_grown > 0) begin
					idx = IndexW'($urandom_range(slots_grown - 1));
					ver = slot_gen[idx];
					op = $urandom_range(1) ? KIND_FREE : KIND_CHECK;
				end else begin
					op = kind_t'(KindW'($urandom_range(3)));
					if ($urandom_range(1))
						ver = slot_gen[idx] + VerW'($urandom_range(2)) - 1'b1;
				end
				issue(op, idx, ver, 1'b0, '0);
			end
			if (seg == SEGMENTS / 2)
				drain_results();
		end
		drain_results();

		// fill the table, then hit it while full, then free slot 63 and allocate again
		while (live_count < SLOTS)
			issue(KIND_ALLOC, IndexW'($urandom), VerW'($urandom), 1'b0, '0);
		repeat (3)
			issue(KIND_ALLOC, 6'd63, 16'hFFFF, 1'b1, '{ST_FULL, 6'd0, 16'h0000});
		issue(KIND_FREE, 6'd63, slot_gen[63], 1'b0, '0);
		issue(KIND_ALLOC, 6'd0, 16'h0000, 1'b0, '0);
		drain_results();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
